// ===== sv/mrope_pkg.sv =====
// Shared types and constants for the multimodal rotary position assigner.
// No dependencies; the top level and the divider import this package.
package mrope_pkg;

  // Fixed field widths of the token stream.
  localparam int MERGE_BITS     = 8;
  localparam int COUNT_BITS     = 16;
  localparam int CFG_INDEX_BITS = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_MERGE_SIZE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_VISION_START_ID = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_ID        = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AUDIO_START_ID  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_AUDIO_ID        = 3'd4;

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_IMAGE = 2'd1,
    MODE_AUDIO = 2'd2
  } run_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_H,
    ST_DIV_W,
    ST_UPDATE
  } seq_state_t;

  // Request to and response from the shared divider.
  typedef struct packed {
    logic                  start;
    logic [COUNT_BITS-1:0] dividend;
    logic [MERGE_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [COUNT_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== sv/mrope_if.sv =====
// Valid/ready channel interfaces for the token input and the position output.
// Depends on nothing but the widths given as parameters.
interface mrope_tok_if #(parameter int TOKEN_BITS = 24);
  logic                  valid;
  logic                  ready;
  logic [TOKEN_BITS-1:0] token_id;
  logic                  grid_valid;
  logic [15:0]           grid_frames;
  logic [15:0]           grid_rows;
  logic [15:0]           grid_cols;
  logic                  audio_valid;
  logic [15:0]           audio_count;
  logic                  last_token;

  modport source (output valid, token_id, grid_valid, grid_frames, grid_rows, grid_cols,
                  audio_valid, audio_count, last_token, input ready);
  modport sink (input valid, token_id, grid_valid, grid_frames, grid_rows, grid_cols,
                audio_valid, audio_count, last_token, output ready);
endinterface

interface mrope_pos_if #(parameter int POSITION_BITS = 20);
  logic                            valid;
  logic                            ready;
  logic [POSITION_BITS-1:0]        pos_temporal;
  logic [POSITION_BITS-1:0]        pos_height;
  logic [POSITION_BITS-1:0]        pos_width;
  logic signed [POSITION_BITS:0]   pos_delta;
  logic                            is_last;

  modport source (output valid, pos_temporal, pos_height, pos_width, pos_delta, is_last,
                  input ready);
  modport sink (input valid, pos_temporal, pos_height, pos_width, pos_delta, is_last,
                output ready);
endinterface

// ===== sv/multimodal_rope_position_assigner.sv =====
// Top level of the multimodal rotary position assigner.
// Depends on mrope_pkg, the channel interfaces in mrope_if and the divider mrope_div.

// The block takes one token per transaction and returns one transaction of temporal,
// height and width positions, plus the delta on the last token of a sequence. Work is
// done one token at a time by a small sequencer: a token passes through accept, decode
// and update, and a vision start with a valid grid also waits on two divisions, since
// the grid height and width are each divided by the merge size in the shared divider,
// which yields one quotient bit per cycle. A finished result waits in
// the output register, so the next token is accepted while the previous result is still
// waiting to be taken; an update stalls only when that register is still full.
module multimodal_rope_position_assigner #(
  parameter int POSITION_BITS = 20,
  parameter int TOKEN_BITS    = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [mrope_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [TOKEN_BITS-1:0]               cfg_data,
  mrope_tok_if.sink                           tokens,
  mrope_pos_if.source                         positions
);
  import mrope_pkg::*;

  localparam int P  = POSITION_BITS;
  localparam int SW = ((P > COUNT_BITS) ? P : COUNT_BITS) + 1;
  localparam int DW = P + 1;
  localparam int CW = COUNT_BITS + 1;

  function automatic logic [P-1:0] sat_add(input logic [P-1:0] base,
                                           input logic [COUNT_BITS-1:0] inc);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(inc);
    if (sum > SW'({P{1'b1}})) begin
      return {P{1'b1}};
    end
    return sum[P-1:0];
  endfunction

  // Configuration registers.
  logic [MERGE_BITS-1:0] merge_size;
  logic [TOKEN_BITS-1:0] vision_start_id;
  logic [TOKEN_BITS-1:0] image_id;
  logic [TOKEN_BITS-1:0] audio_start_id;
  logic [TOKEN_BITS-1:0] audio_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_size      <= MERGE_BITS'(2);
      vision_start_id <= '0;
      image_id        <= '0;
      audio_start_id  <= '0;
      audio_id        <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MERGE_SIZE:      merge_size      <= cfg_data[MERGE_BITS-1:0];
        REG_VISION_START_ID: vision_start_id <= cfg_data;
        REG_IMAGE_ID:        image_id        <= cfg_data;
        REG_AUDIO_START_ID:  audio_start_id  <= cfg_data;
        REG_AUDIO_ID:        audio_id        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latched input transaction.
  logic [TOKEN_BITS-1:0] item_token;
  logic                  item_grid_valid;
  logic [COUNT_BITS-1:0] item_frames;
  logic [COUNT_BITS-1:0] item_rows;
  logic [COUNT_BITS-1:0] item_cols;
  logic                  item_audio_valid;
  logic [COUNT_BITS-1:0] item_audio_count;
  logic                  item_last;

  seq_state_t state, state_next;
  logic       accept;
  logic       commit;
  logic       out_valid;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [COUNT_BITS-1:0] rows_merged;
  logic [COUNT_BITS-1:0] cols_merged;

  assign accept = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_token       <= tokens.token_id;
      item_grid_valid  <= tokens.grid_valid;
      item_frames      <= tokens.grid_frames;
      item_rows        <= tokens.grid_rows;
      item_cols        <= tokens.grid_cols;
      item_audio_valid <= tokens.audio_valid;
      item_audio_count <= tokens.audio_count;
      item_last        <= tokens.last_token;
    end
  end

  // Sequence state.
  run_mode_t             run_mode, run_mode_next;
  logic [P-1:0]          next_position, next_position_next;
  logic [P-1:0]          run_base, run_base_next;
  logic [COUNT_BITS-1:0] frame_count, frame_count_next;
  logic [COUNT_BITS-1:0] row_count, row_count_next;
  logic [COUNT_BITS-1:0] col_count, col_count_next;
  logic [COUNT_BITS-1:0] run_frames, run_frames_next;
  logic [COUNT_BITS-1:0] run_rows, run_rows_next;
  logic [COUNT_BITS-1:0] run_cols, run_cols_next;
  logic [P-1:0]          max_temporal, max_temporal_next;
  logic [P-1:0]          tokens_seen, tokens_seen_next;

  // Token classification against the current run.
  logic is_image_tok;
  logic is_audio_tok;
  logic vis_open;
  logic aud_open;

  assign is_image_tok = (run_mode == MODE_IMAGE) && (item_token == image_id);
  assign is_audio_tok = (run_mode == MODE_AUDIO) && (item_token == audio_id);
  assign vis_open = !is_image_tok && !is_audio_tok &&
                    (item_token == vision_start_id) && item_grid_valid;
  assign aud_open = !is_image_tok && !is_audio_tok && !vis_open &&
                    (item_token == audio_start_id) && item_audio_valid;

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (tokens.valid) state_next = ST_DECODE;
      ST_DECODE: state_next = vis_open ? ST_DIV_H : ST_UPDATE;
      ST_DIV_H:  if (div_rsp.done) state_next = ST_DIV_W;
      ST_DIV_W:  if (div_rsp.done) state_next = ST_UPDATE;
      ST_UPDATE: if (commit) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    tokens.ready     = 1'b0;
    commit           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = item_rows;
    div_req.divisor  = (merge_size == '0) ? MERGE_BITS'(1) : merge_size;
    case (state)
      ST_IDLE:   tokens.ready = 1'b1;
      ST_DECODE: div_req.start = vis_open;
      ST_DIV_H: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = item_cols;
      end
      ST_DIV_W:  ;
      ST_UPDATE: commit = !out_valid || positions.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV_H && div_rsp.done) begin
      rows_merged <= div_rsp.quotient;
    end
    if (state == ST_DIV_W && div_rsp.done) begin
      cols_merged <= div_rsp.quotient;
    end
  end

  mrope_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Position update for one token.
  logic [P-1:0]          pt, ph, pw;
  logic [COUNT_BITS-1:0] big;
  logic [CW-1:0]         col_inc, row_inc, frame_inc;
  logic signed [DW-1:0]  delta;

  always_comb begin
    big = item_frames;
    if (rows_merged > big) big = rows_merged;
    if (cols_merged > big) big = cols_merged;
  end

  assign col_inc   = {1'b0, col_count} + CW'(1);
  assign row_inc   = {1'b0, row_count} + CW'(1);
  assign frame_inc = {1'b0, frame_count} + CW'(1);

  always_comb begin
    run_mode_next      = MODE_TEXT;
    next_position_next = next_position;
    run_base_next      = run_base;
    frame_count_next   = frame_count;
    row_count_next     = row_count;
    col_count_next     = col_count;
    run_frames_next    = run_frames;
    run_rows_next      = run_rows;
    run_cols_next      = run_cols;
    pt                 = next_position;
    ph                 = next_position;
    pw                 = next_position;
    delta              = '0;

    if (is_image_tok) begin
      pt            = sat_add(run_base, frame_count);
      ph            = sat_add(run_base, row_count);
      pw            = sat_add(run_base, col_count);
      run_mode_next = MODE_IMAGE;
      if (col_inc >= {1'b0, run_cols}) begin
        col_count_next = '0;
        if (row_inc >= {1'b0, run_rows}) begin
          row_count_next   = '0;
          frame_count_next = frame_inc[COUNT_BITS-1:0];
          if (frame_inc >= {1'b0, run_frames}) begin
            run_mode_next = MODE_TEXT;
          end
        end else begin
          row_count_next = row_inc[COUNT_BITS-1:0];
        end
      end else begin
        col_count_next = col_inc[COUNT_BITS-1:0];
      end
    end else if (is_audio_tok) begin
      pt             = sat_add(run_base, col_count);
      ph             = pt;
      pw             = pt;
      col_count_next = col_inc[COUNT_BITS-1:0];
      run_mode_next  = (col_inc >= {1'b0, run_cols}) ? MODE_TEXT : MODE_AUDIO;
    end else if (vis_open) begin
      run_base_next      = sat_add(next_position, COUNT_BITS'(1));
      next_position_next = sat_add(run_base_next, big);
      frame_count_next   = '0;
      row_count_next     = '0;
      col_count_next     = '0;
      run_frames_next    = item_frames;
      run_rows_next      = rows_merged;
      run_cols_next      = cols_merged;
      if (item_frames != '0 && rows_merged != '0 && cols_merged != '0) begin
        run_mode_next = MODE_IMAGE;
      end
    end else if (aud_open) begin
      run_base_next      = sat_add(next_position, COUNT_BITS'(1));
      next_position_next = sat_add(run_base_next, item_audio_count);
      frame_count_next   = '0;
      row_count_next     = '0;
      col_count_next     = '0;
      run_frames_next    = '0;
      run_rows_next      = '0;
      run_cols_next      = item_audio_count;
      if (item_audio_count != '0) begin
        run_mode_next = MODE_AUDIO;
      end
    end else begin
      next_position_next = sat_add(next_position, COUNT_BITS'(1));
    end

    max_temporal_next = (pt > max_temporal) ? pt : max_temporal;
    tokens_seen_next  = sat_add(tokens_seen, COUNT_BITS'(1));

    if (item_last) begin
      // At least one token has been counted, so the delta stays inside its signed range.
      delta = signed'(DW'(max_temporal_next) + DW'(1) - DW'(tokens_seen_next));
      run_mode_next      = MODE_TEXT;
      next_position_next = '0;
      run_base_next      = '0;
      frame_count_next   = '0;
      row_count_next     = '0;
      col_count_next     = '0;
      run_frames_next    = '0;
      run_rows_next      = '0;
      run_cols_next      = '0;
      max_temporal_next  = '0;
      tokens_seen_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode      <= MODE_TEXT;
      next_position <= '0;
      run_base      <= '0;
      frame_count   <= '0;
      row_count     <= '0;
      col_count     <= '0;
      run_frames    <= '0;
      run_rows      <= '0;
      run_cols      <= '0;
      max_temporal  <= '0;
      tokens_seen   <= '0;
    end else if (commit) begin
      run_mode      <= run_mode_next;
      next_position <= next_position_next;
      run_base      <= run_base_next;
      frame_count   <= frame_count_next;
      row_count     <= row_count_next;
      col_count     <= col_count_next;
      run_frames    <= run_frames_next;
      run_rows      <= run_rows_next;
      run_cols      <= run_cols_next;
      max_temporal  <= max_temporal_next;
      tokens_seen   <= tokens_seen_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (positions.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      positions.pos_temporal <= pt;
      positions.pos_height   <= ph;
      positions.pos_width    <= pw;
      positions.pos_delta    <= delta;
      positions.is_last      <= item_last;
    end
  end

  assign positions.valid = out_valid;

endmodule

// ===== sv/mrope_div.sv =====
// Restoring divider, one quotient bit per cycle, for grid size over merge size.
// Depends on mrope_pkg for the request and response structs.
module mrope_div (
  input  logic                clk,
  input  logic                rst,
  input  mrope_pkg::div_req_t req,
  output mrope_pkg::div_rsp_t rsp
);
  import mrope_pkg::*;

  localparam int STEP_BITS = $clog2(COUNT_BITS);

  logic                  busy;
  logic                  done;
  logic [STEP_BITS-1:0]  step;
  logic [MERGE_BITS-1:0] rem;
  logic [MERGE_BITS-1:0] dvsr;
  logic [COUNT_BITS-1:0] quo;
  logic [MERGE_BITS:0]   trial;
  logic                  fits;

  assign trial = {rem, quo[COUNT_BITS-1]};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(COUNT_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of quo as the quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= MERGE_BITS'(trial - {1'b0, dvsr});
      end else begin
        rem <= trial[MERGE_BITS-1:0];
      end
      quo <= {quo[COUNT_BITS-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// ===== sv/mrope_checker.sv =====
// Port-level checks for the multimodal rotary position assigner, bound to its top level.
// Depends only on the top level's ports.
module mrope_checker #(
  parameter int DELTA_BITS = 21
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_last,
  input logic signed [DELTA_BITS-1:0] out_delta
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // One token at a time: no new transaction right after one is accepted.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an accepted transaction");

  // A token passes through decode before its result appears.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

  // The delta is only reported on the last token.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last |-> out_delta == '0)
    else $error("nonzero delta on a token that is not last");

endmodule

bind multimodal_rope_position_assigner mrope_checker #(
  .DELTA_BITS (POSITION_BITS + 1)
) u_mrope_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (tokens.valid),
  .in_ready  (tokens.ready),
  .out_valid (positions.valid),
  .out_ready (positions.ready),
  .out_last  (positions.is_last),
  .out_delta (positions.pos_delta)
);
